FILE: rtl/tfd_pkg.sv
// tfd_pkg: shared types and constants of the temperature frame deframer.
// Used by tfd_core, tfd_result_queue and temperature_frame_deframer.
// No dependencies.
package tfd_pkg;

	// Sync window depth (bytes kept while hunting)
	localparam int WinBytes = 8;
	localparam int FillW    = $clog2(WinBytes + 1);

	// Frame byte position, saturating at all ones
	localparam int              PosW   = 13;
	localparam logic [PosW-1:0] PosMax = '1;
	localparam int              IdxW   = PosW - 2;

	// Stream markers
	localparam logic [7:0] SyncByte = 8'h00;
	localparam logic [7:0] EndByte0 = 8'h2f;
	localparam logic [7:0] EndByte1 = 8'h27;

	// Configuration register file
	localparam int              AddrW         = 3;
	localparam int              RegIdxW       = AddrW - 2;
	localparam logic [RegIdxW-1:0] RegExpected = '0;
	localparam logic [PosW-1:0] ExpectedReset = 13'd7684;

	// Result queue
	localparam int QDepth = 4;
	localparam int QPtrW  = $clog2(QDepth);
	localparam int QCntW  = $clog2(QDepth + 1);

	typedef enum logic {
		KindRecord = 1'b0,
		KindEnd    = 1'b1
	} tfd_kind_t;

	typedef struct packed {
		tfd_kind_t       kind;
		logic [IdxW-1:0] record_index;
		logic [15:0]     temp_raw;
		logic [7:0]      sensor_channel;
		logic [7:0]      sensor_layer;
		logic [7:0]      stamp_day;
		logic [7:0]      stamp_hour;
		logic [7:0]      stamp_minute;
		logic [7:0]      stamp_second;
		logic            frame_good;
		logic [PosW-1:0] frame_length;
		logic            last_of_item;
	} tfd_result_t;

	// Up to two results written into the queue in one cycle
	typedef struct packed {
		logic [1:0]  count;
		tfd_result_t first;
		tfd_result_t second;
	} tfd_push_t;

endpackage

FILE: rtl/temperature_frame_deframer.sv
// temperature_frame_deframer: top level, APB register and channel wiring.
// Depends on tfd_pkg, tfd_core and tfd_result_queue.
//
// Usage notes:
// - Input channel (in_valid/in_stall/data_byte): one raw readout byte per item.
//   An item is taken on a rising edge with in_valid high and in_stall low.
// - Output channel (out_valid/out_stall + payload): sensor records
//   (result_kind 0) and frame end status (result_kind 1). last_of_item marks
//   the final result of the byte that caused it; a byte gives zero, one or two.
// - Path: a byte waits in the input register until the queue has room.
// - Throughput: one byte per cycle while in_stall is low. A byte that closes
//   both a record and the frame yields two results, drained one per cycle
//   from a 4-entry queue while out_stall is low.
// - in_stall rises when the input register holds a byte and the queue lacks
//   room for two results; out_stall holding results back fills the queue and
//   then backs up into in_stall. No result is dropped.
// - Reset (arst_n low) puts the block in sync hunt with an empty queue and
//   expected_frame_bytes = 7684.
// - APB register 0 (byte address 0): expected_frame_bytes, bits 12:0.
//   Write it only while no byte is in flight.
module temperature_frame_deframer import tfd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	// byte input
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [7:0]       data_byte,
	// result output
	output logic             out_valid,
	input  logic             out_stall,
	output logic             result_kind,
	output logic [IdxW-1:0]  record_index,
	output logic [15:0]      temp_raw,
	output logic [7:0]       sensor_channel,
	output logic [7:0]       sensor_layer,
	output logic [7:0]       stamp_day,
	output logic [7:0]       stamp_hour,
	output logic [7:0]       stamp_minute,
	output logic [7:0]       stamp_second,
	output logic             frame_good,
	output logic [PosW-1:0]  frame_length,
	output logic             last_of_item,
	// configuration
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [AddrW-1:0] paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic [PosW-1:0] expected_q;
	logic            reg_hit;
	logic            room;
	tfd_push_t       push;
	tfd_result_t     head;

	// register index is the word address; anything else is ignored on write
	assign reg_hit = (paddr[AddrW-1:2] == RegExpected);
	assign pready  = 1'b1;
	assign prdata  = reg_hit ? 32'(expected_q) : 32'h0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_q <= ExpectedReset;
		end else if (psel && penable && pwrite && reg_hit) begin
			expected_q <= pwdata[PosW-1:0];
		end
	end

	tfd_core u_core (
		.clk                  (clk),
		.arst_n               (arst_n),
		.in_valid             (in_valid),
		.in_stall             (in_stall),
		.data_byte            (data_byte),
		.expected_frame_bytes (expected_q),
		.room                 (room),
		.push                 (push)
	);

	tfd_result_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.head      (head)
	);

	assign result_kind    = head.kind;
	assign record_index   = head.record_index;
	assign temp_raw       = head.temp_raw;
	assign sensor_channel = head.sensor_channel;
	assign sensor_layer   = head.sensor_layer;
	assign stamp_day      = head.stamp_day;
	assign stamp_hour     = head.stamp_hour;
	assign stamp_minute   = head.stamp_minute;
	assign stamp_second   = head.stamp_second;
	assign frame_good     = head.frame_good;
	assign frame_length   = head.frame_length;
	assign last_of_item   = head.last_of_item;

endmodule

FILE: rtl/tfd_core.sv
// tfd_core: input register, sync hunt and frame collection state, result build.
// Depends on tfd_pkg; feeds tfd_result_queue.
module tfd_core import tfd_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic [7:0]      data_byte,
	input  logic [PosW-1:0] expected_frame_bytes,
	input  logic            room,
	output tfd_push_t       push
);

	logic            valid_s1;
	logic [7:0]      byte_s1;
	logic            proc;
	logic            in_fire;

	logic            hunting_q;
	logic [7:0]      prev_q;
	logic [7:0]      win_q [WinBytes];
	logic [FillW-1:0] fill_q;
	logic [PosW-1:0] pos_q;
	logic [3:0][7:0] stamp_q;
	logic [2:0][7:0] part_q;

	// hunt path
	logic            win_full;
	logic [7:0]      win_new [WinBytes];
	logic [FillW-1:0] fill_new;
	logic [FillW-1:0] sync_last;
	logic            sync_hit;
	logic            sync_rec;
	logic [IdxW-1:0] sync_idx;
	logic [3:0][7:0] stamp_sync;
	logic [2:0][7:0] part_sync;

	// collect path
	logic            pos_lt4;
	logic [1:0]      grp_k;
	logic [3:0][7:0] stamp_col;
	logic [2:0][7:0] part_col;
	logic            col_rec;
	logic [IdxW-1:0] col_idx;
	logic [PosW-1:0] pos_inc;
	logic            end_hit;

	tfd_result_t     rec;
	tfd_result_t     endr;

	assign proc     = valid_s1 && room;
	assign in_stall = valid_s1 && !room;
	assign in_fire  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (proc) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			byte_s1 <= data_byte;
		end
	end

	// Hunting: window fill/shift, sync detect, window unpacked as frame positions
	always_comb begin
		win_full = (fill_q == FillW'(WinBytes));
		for (int i = 0; i < WinBytes - 1; i++) begin
			if (win_full) begin
				win_new[i] = win_q[i+1];
			end else begin
				win_new[i] = (fill_q == FillW'(i)) ? byte_s1 : win_q[i];
			end
		end
		win_new[WinBytes-1] = (win_full || fill_q == FillW'(WinBytes - 1)) ?
			byte_s1 : win_q[WinBytes-1];
		fill_new = win_full ? fill_q : fill_q + FillW'(1);
		sync_hit = (prev_q == SyncByte) && (byte_s1 == SyncByte);
		for (int i = 0; i < 4; i++) begin
			stamp_sync[i] = (FillW'(i) < fill_new) ? win_new[i] : 8'h00;
		end
		for (int k = 0; k < 3; k++) begin
			part_sync[k] = 8'h00;
			for (int p = 4; p < WinBytes; p++) begin
				if ((((p - 4) & 3) == k) && (FillW'(p) < fill_new)) begin
					part_sync[k] = win_new[p];
				end
			end
		end
		sync_last = fill_new - FillW'(1);
		sync_rec  = (sync_last >= FillW'(4)) && (sync_last[1:0] == 2'd3) &&
			(PosW'(sync_last) < expected_frame_bytes);
		sync_idx  = IdxW'(sync_last >> 2) - IdxW'(1);
	end

	// Collecting: stamp bytes, record bytes, end marker
	always_comb begin
		pos_lt4   = (pos_q[PosW-1:2] == '0);
		grp_k     = pos_q[1:0];
		stamp_col = stamp_q;
		if (pos_lt4) begin
			stamp_col[pos_q[1:0]] = byte_s1;
		end
		part_col = part_q;
		for (int j = 0; j < 3; j++) begin
			if (!pos_lt4 && grp_k == 2'(j)) begin
				part_col[j] = byte_s1;
			end
		end
		col_rec = !pos_lt4 && (grp_k == 2'd3) && (pos_q < expected_frame_bytes);
		col_idx = pos_q[PosW-1:2] - IdxW'(1);
		pos_inc = (pos_q == PosMax) ? pos_q : pos_q + PosW'(1);
		end_hit = (prev_q == EndByte0) && (byte_s1 == EndByte1);
	end

	always_comb begin
		rec  = '0;
		rec.kind         = KindRecord;
		rec.sensor_layer = byte_s1;
		if (hunting_q) begin
			rec.record_index   = sync_idx;
			rec.temp_raw       = {part_sync[0], part_sync[1]};
			rec.sensor_channel = part_sync[2];
		end else begin
			rec.record_index   = col_idx;
			rec.temp_raw       = {part_col[0], part_col[1]};
			rec.sensor_channel = part_col[2];
		end

		endr = '0;
		endr.kind         = KindEnd;
		endr.stamp_day    = stamp_col[0];
		endr.stamp_hour   = stamp_col[1];
		endr.stamp_minute = stamp_col[2];
		endr.stamp_second = stamp_col[3];
		endr.frame_good   = (pos_inc == expected_frame_bytes);
		endr.frame_length = pos_inc;
		endr.last_of_item = 1'b1;

		push = '0;
		if (proc) begin
			if (hunting_q) begin
				if (sync_hit && sync_rec) begin
					push.count              = 2'd1;
					push.first              = rec;
					push.first.last_of_item = 1'b1;
				end
			end else if (col_rec && end_hit) begin
				push.count  = 2'd2;
				push.first  = rec;
				push.second = endr;
			end else if (col_rec) begin
				push.count              = 2'd1;
				push.first              = rec;
				push.first.last_of_item = 1'b1;
			end else if (end_hit) begin
				push.count = 2'd1;
				push.first = endr;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hunting_q <= 1'b1;
			prev_q    <= 8'h00;
			fill_q    <= '0;
			pos_q     <= '0;
			stamp_q   <= '0;
			part_q    <= '0;
		end else if (proc) begin
			if (hunting_q) begin
				fill_q <= fill_new;
				if (sync_hit) begin
					hunting_q <= 1'b0;
					stamp_q   <= stamp_sync;
					part_q    <= part_sync;
					pos_q     <= PosW'(fill_new);
				end else begin
					prev_q <= byte_s1;
				end
			end else begin
				stamp_q <= stamp_col;
				part_q  <= part_col;
				if (end_hit) begin
					hunting_q <= 1'b1;
					prev_q    <= 8'h00;
					fill_q    <= '0;
					pos_q     <= '0;
				end else begin
					prev_q <= byte_s1;
					pos_q  <= pos_inc;
				end
			end
		end
	end

	// window bytes are never read before they are written
	always_ff @(posedge clk) begin
		if (proc && hunting_q) begin
			for (int i = 0; i < WinBytes; i++) begin
				win_q[i] <= win_new[i];
			end
		end
	end

`ifndef SYNTHESIS
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !proc |=> valid_s1 && $stable(byte_s1))
		else $error("input register lost a stalled item");
	a_fill_max: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FillW'(WinBytes))
		else $error("window fill beyond depth");
	a_end_rearm: assert property (@(posedge clk) disable iff (!arst_n)
		proc && !hunting_q && end_hit |=> hunting_q && fill_q == '0 && pos_q == '0)
		else $error("end marker did not restart the hunt");
	a_two_only_end: assert property (@(posedge clk) disable iff (!arst_n)
		push.count == 2'd2 |-> !hunting_q && end_hit && col_rec)
		else $error("double push without record and end marker");
`endif

endmodule

FILE: rtl/tfd_result_queue.sv
// tfd_result_queue: four-entry result queue, up to two writes and one read a cycle.
// Depends on tfd_pkg; fed by tfd_core.
module tfd_result_queue import tfd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  tfd_push_t   push,
	output logic        room,
	output logic        out_valid,
	input  logic        out_stall,
	output tfd_result_t head
);

	tfd_result_t      mem_q [QDepth];
	logic [QPtrW-1:0] wr_ptr_q;
	logic [QPtrW-1:0] rd_ptr_q;
	logic [QCntW-1:0] cnt_q;
	logic             pop;

	assign out_valid = (cnt_q != '0);
	assign pop       = out_valid && !out_stall;
	assign room      = (cnt_q <= QCntW'(QDepth - 2));
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wr_ptr_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			mem_q[wr_ptr_q + QPtrW'(1)] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPtrW'(push.count);
			rd_ptr_q <= rd_ptr_q + QPtrW'(pop);
			cnt_q    <= cnt_q + QCntW'(push.count) - QCntW'(pop);
		end
	end

`ifndef SYNTHESIS
	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCntW'(QDepth))
		else $error("result queue overflow");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.count != 2'd0 |-> cnt_q <= QCntW'(QDepth - 2))
		else $error("write into a queue without room for two");
	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == '0 |-> rd_ptr_q == wr_ptr_q)
		else $error("empty queue with pointers apart");
`endif

endmodule
